[hw/rtl/jerk_motion_detector_top_macros.svh]
// ----------------------------------------------------------------------------
// Jerk motion detector assertion macros
// Shared concurrent assertion forms, clocked on aclk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef JERK_MOTION_DETECTOR_TOP_MACROS_SVH
`define JERK_MOTION_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define JMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/jmd_pkg.sv]
// ----------------------------------------------------------------------------
// Jerk motion detector package
// Widths, register indexes, reset constants and the control/status bundles.
// ----------------------------------------------------------------------------
package jmd_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int ACC_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int JERK_W     = 24;
    localparam int HOLD_W     = 16;
    localparam int RUN_W      = 3;
    localparam int SUMSQ_W    = 32;
    localparam int MAG_W      = ACC_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = JERK_W;
    localparam int IN_DATA_W  = 3 * ACC_W + STAMP_W;
    localparam int OUT_DATA_W = 32;
    localparam int SQ_STEPS   = 4;

    localparam logic [JERK_W-1:0] JERK_MAX = '1;

    // reset values: motion limit is 1.5 held as 3/2
    localparam int MOTION_LIMIT_X2 = 3;
    localparam int FAULT_LIMIT_INT = 500;
    localparam int HOLD_RST        = 200;
    localparam int RUN_RST         = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MOTION_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_WINDOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_RUN    = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef struct packed {
        logic [JERK_W-1:0] motion_jerk_limit;
        logic [JERK_W-1:0] fault_jerk_limit;
        logic [HOLD_W-1:0] hold_window_ms;
        logic [RUN_W-1:0]  fault_run_limit;
    } cfg_t;

    typedef struct packed {
        logic  load;
        logic  sq_step;
        axis_t sq_axis;
        logic  prep;
        logic  root_step;
        logic  div_step;
        logic  fin;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic dt_bad;
    } sts_t;

endpackage

[hw/rtl/jmd_cfg.sv]
// ----------------------------------------------------------------------------
// Jerk motion detector configuration registers
// Register file written through the index/data write channel.
// ----------------------------------------------------------------------------
module jmd_cfg
    import jmd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam logic [JERK_W-1:0] MOTION_RST =
        JERK_W'((64'(MOTION_LIMIT_X2) << FRAC_BITS) >> 1);
    localparam logic [63:0] FAULT_FULL = 64'(FAULT_LIMIT_INT) << FRAC_BITS;
    localparam logic [JERK_W-1:0] FAULT_RST =
        (FAULT_FULL > 64'(JERK_MAX)) ? JERK_MAX : JERK_W'(FAULT_FULL);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MOTION_LIMIT: cfg_next.motion_jerk_limit = cfg_data;
                REG_FAULT_LIMIT:  cfg_next.fault_jerk_limit  = cfg_data;
                REG_HOLD_WINDOW:  cfg_next.hold_window_ms    = cfg_data[HOLD_W-1:0];
                REG_FAULT_RUN:    cfg_next.fault_run_limit   = cfg_data[RUN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motion_jerk_limit <= MOTION_RST;
            cfg_reg.fault_jerk_limit  <= FAULT_RST;
            cfg_reg.hold_window_ms    <= HOLD_W'(HOLD_RST);
            cfg_reg.fault_run_limit   <= RUN_W'(RUN_RST);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/jmd_dp.sv]
// ----------------------------------------------------------------------------
// Jerk motion detector datapath
// Squared differences, bit-serial root and divide, motion and fault tracking.
// ----------------------------------------------------------------------------
`include "jerk_motion_detector_top_macros.svh"

module jmd_dp
    import jmd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  cfg_t                  cfg,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int SW = SUMSQ_W + 2 * FRAC_BITS;
    localparam int RW = SW / 2;
    localparam int EW = (RW > JERK_W) ? RW : JERK_W + 1;

    logic [ACC_W-1:0]   cur_x_reg, cur_y_reg, cur_z_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [ACC_W-1:0]   prev_x_reg, prev_y_reg, prev_z_reg;
    logic [STAMP_W-1:0] prev_stamp_reg;
    logic [STAMP_W-1:0] lms_reg;
    logic [RUN_W-1:0]   fault_run_reg;
    logic [STAMP_W-1:0] dt_reg;
    logic               dt_bad_reg;
    logic [SUMSQ_W-1:0] prod_reg;
    logic [SUMSQ_W-1:0] acc_reg;
    logic [SW-1:0]      rad_reg;
    logic [RW+1:0]      rem_reg;
    logic [RW-1:0]      root_reg;
    logic [STAMP_W-1:0] drem_reg;
    logic [JERK_W-1:0]  jerk_reg;
    logic               reinit_reg;
    logic [JERK_W-1:0]  out_jerk_reg;
    logic               out_motion_reg, out_reinit_reg, out_upside_reg;

    logic [ACC_W-1:0]   in_x, in_y, in_z;
    logic [STAMP_W-1:0] in_stamp, dt_c;
    logic [ACC_W-1:0]   cur_sel, prev_sel, diff;
    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] prod_w;
    logic [RW+1:0]      rem_sh, trial;
    logic               root_bit;
    logic [STAMP_W-1:0] dsh;
    logic               div_bit;
    logic [EW-1:0]      q_ext;
    logic [JERK_W-1:0]  jerk_c;
    logic [RUN_W:0]     run_inc;
    logic               fault_c, reinit_c;
    logic [RUN_W-1:0]   run_c;
    logic [STAMP_W-1:0] age;
    logic               motion_c;

    assign in_x     = in_data[ACC_W-1:0];
    assign in_y     = in_data[2*ACC_W-1:ACC_W];
    assign in_z     = in_data[3*ACC_W-1:2*ACC_W];
    assign in_stamp = in_data[IN_DATA_W-1:3*ACC_W];
    assign dt_c     = in_stamp - prev_stamp_reg;

    always_comb begin
        case (cmd.sq_axis)
            AXIS_X: begin
                cur_sel  = cur_x_reg;
                prev_sel = prev_x_reg;
            end
            AXIS_Y: begin
                cur_sel  = cur_y_reg;
                prev_sel = prev_y_reg;
            end
            AXIS_Z: begin
                cur_sel  = cur_z_reg;
                prev_sel = prev_z_reg;
            end
            default: begin
                cur_sel  = '0;
                prev_sel = '0;
            end
        endcase
    end

    assign diff   = cur_sel - prev_sel;
    assign mag    = diff[ACC_W-1] ? (MAG_W'(1) << ACC_W) - MAG_W'(diff) : MAG_W'(diff);
    assign prod_w = mag * mag;

    // root: two radicand bits per step
    assign rem_sh   = {rem_reg[RW-1:0], rad_reg[SW-1:SW-2]};
    assign trial    = {root_reg, 2'b01};
    assign root_bit = (rem_sh >= trial);

    // restoring divide, quotient shifts into root_reg
    assign dsh     = {drem_reg[STAMP_W-2:0], root_reg[RW-1]};
    assign div_bit = (dsh >= dt_reg);

    assign q_ext   = EW'(root_reg);
    assign jerk_c  = (dt_bad_reg || q_ext > EW'(JERK_MAX)) ? JERK_MAX : JERK_W'(q_ext);
    assign run_inc = {1'b0, fault_run_reg} + (RUN_W+1)'(1);
    assign fault_c = (jerk_c > cfg.fault_jerk_limit);

    always_comb begin
        reinit_c = 1'b0;
        run_c    = '0;
        if (fault_c) begin
            if (run_inc > {1'b0, cfg.fault_run_limit}) begin
                reinit_c = 1'b1;
            end else begin
                run_c = run_inc[RUN_W-1:0];
            end
        end
    end

    assign age      = stamp_reg - lms_reg;
    assign motion_c = age[STAMP_W-1] || (age <= STAMP_W'(cfg.hold_window_ms));

    assign sts.dt_bad = dt_bad_reg;
    assign out_data   = OUT_DATA_W'({out_upside_reg, out_reinit_reg, out_motion_reg,
                                     out_jerk_reg});

    // sample history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_z_reg     <= '0;
            prev_stamp_reg <= '0;
            lms_reg        <= '0;
            fault_run_reg  <= '0;
        end else if (cmd.fin) begin
            prev_x_reg     <= cur_x_reg;
            prev_y_reg     <= cur_y_reg;
            prev_z_reg     <= cur_z_reg;
            prev_stamp_reg <= stamp_reg;
            fault_run_reg  <= run_c;
            if (jerk_c > cfg.motion_jerk_limit) begin
                lms_reg <= stamp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_x_reg  <= in_x;
            cur_y_reg  <= in_y;
            cur_z_reg  <= in_z;
            stamp_reg  <= in_stamp;
            dt_reg     <= dt_c;
            dt_bad_reg <= (dt_c == '0) || dt_c[STAMP_W-1];
            acc_reg    <= '0;
        end
        if (cmd.sq_step) begin
            prod_reg <= prod_w[SUMSQ_W-1:0];
            if (cmd.sq_axis != AXIS_X) begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
        if (cmd.prep) begin
            rad_reg  <= SW'(acc_reg) << (2 * FRAC_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
            drem_reg <= '0;
        end
        if (cmd.root_step) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= root_bit ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RW-2:0], root_bit};
        end
        if (cmd.div_step) begin
            drem_reg <= div_bit ? dsh - dt_reg : dsh;
            root_reg <= {root_reg[RW-2:0], div_bit};
        end
        if (cmd.fin) begin
            jerk_reg   <= jerk_c;
            reinit_reg <= reinit_c;
        end
        if (cmd.out_load) begin
            out_jerk_reg   <= jerk_reg;
            out_motion_reg <= motion_c;
            out_reinit_reg <= reinit_reg;
            out_upside_reg <= cur_z_reg[ACC_W-1];
        end
    end

    `JMD_ASSERT_NXT(a_reinit_clears_run, cmd.fin && reinit_c, fault_run_reg == '0,
        "reinit request left a fault run count")
    `JMD_ASSERT_IMP(a_bad_dt_saturates, cmd.fin && dt_bad_reg, jerk_c == JERK_MAX,
        "non-positive time step did not saturate jerk")
    `JMD_ASSERT_NXT(a_run_within_limit, cmd.fin, fault_run_reg <= $past(cfg.fault_run_limit),
        "fault run count above its limit")

endmodule

[hw/rtl/jmd_ctrl.sv]
// ----------------------------------------------------------------------------
// Jerk motion detector controller
// Sequences squaring, root, divide and result hand-off; owns the stream handshakes.
// ----------------------------------------------------------------------------
`include "jerk_motion_detector_top_macros.svh"

module jmd_ctrl
    import jmd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam int RW = (SUMSQ_W + 2 * FRAC_BITS) / 2;
    localparam int CW = $clog2(RW + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQR  = 7'b0000010,
        ST_PREP = 7'b0000100,
        ST_ROOT = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sq_axis = AXIS_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                cmd.sq_step = 1'b1;
                cmd.sq_axis = axis_t'(cnt_reg[1:0]);
                if (cnt_reg == CW'(SQ_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_PREP;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.dt_bad ? ST_FIN : ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CW'(RW - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(RW - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `JMD_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || m_tready,
        "result word overwritten before it was taken")
    `JMD_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_SQR,
        "accepted word did not start the squaring pass")
    `JMD_ASSERT_IMP(a_cnt_bound, state_reg == ST_ROOT || state_reg == ST_DIV,
        cnt_reg <= CW'(RW - 1), "bit counter ran past the operand width")

endmodule

[hw/rtl/jerk_motion_detector_top.sv]
// ----------------------------------------------------------------------------
// Jerk motion detector
// Each input word (x, y, z acceleration and a ms stamp) yields one result word:
// jerk (difference magnitude per ms, FRAC_BITS fraction bits, saturated),
// motion within the hold window, a reinitialise request and an upside-down flag.
// One word is processed at a time; the next word is accepted only once the result
// of the last one is loaded into the output register. The bit-serial square root and
// the restoring divide each produce one result bit per cycle; a word with a zero or
// negative time step skips both. A finished result waits in the output register
// while the next word is being worked on. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module jerk_motion_detector_top
    import jmd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z, stamp_ms
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // jerk_value, motion, reinit_request,
                                             // upside_down, zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    jmd_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jmd_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    jmd_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

[tb/sv/jerk_motion_detector_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jerk motion detector testbench
// Feeds acceleration/stamp words through the stream input and checks every
// result word against a cycle-free prediction of jerk, motion hold, fault runs
// and the upside-down flag. A directed opener covers wrapped differences, bad
// time steps, stamp wrap, hold-window edges and the reinitialise request; then
// random sample tracks run under several register settings, extremes included.
// ----------------------------------------------------------------------------
module jerk_motion_detector_top_tb;
    import jmd_pkg::*;

    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 23;

    typedef enum int {
        TRACK_QUIET,
        TRACK_MOVING,
        TRACK_VIOLENT
    } track_mode_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp_ms;
        logic [ACC_W-1:0]   accel_z;
        logic [ACC_W-1:0]   accel_y;
        logic [ACC_W-1:0]   accel_x;
    } sample_t;

    typedef struct packed {
        logic [JERK_W-1:0] jerk_value;
        logic              motion;
        logic              reinit_request;
        logic              upside_down;
    } result_t;

    class jerk_tracker;
        logic [JERK_W-1:0]  motion_limit;
        logic [JERK_W-1:0]  fault_limit;
        logic [HOLD_W-1:0]  hold_ms;
        logic [RUN_W-1:0]   run_limit;
        sample_t            prior;
        logic [STAMP_W-1:0] motion_stamp;
        logic [RUN_W-1:0]   fault_run;
        result_t            pending_results[$];
        int                 errors;

        function new();
            longint unsigned fault_fx;
            fault_fx     = longint'(FAULT_LIMIT_INT) << FRAC;
            motion_limit = JERK_W'((longint'(MOTION_LIMIT_X2) << FRAC) >> 1);
            fault_limit  = (fault_fx > longint'(JERK_MAX)) ? JERK_MAX : JERK_W'(fault_fx);
            hold_ms      = HOLD_W'(HOLD_RST);
            run_limit    = RUN_W'(RUN_RST);
            prior        = '0;
            motion_stamp = '0;
            fault_run    = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MOTION_LIMIT: motion_limit = val[JERK_W-1:0];
                REG_FAULT_LIMIT:  fault_limit  = val[JERK_W-1:0];
                REG_HOLD_WINDOW:  hold_ms      = val[HOLD_W-1:0];
                REG_FAULT_RUN:    run_limit    = val[RUN_W-1:0];
                default: ;
            endcase
        endfunction

        // magnitude of a 16-bit wrapped difference
        function logic [MAG_W-1:0] wrap_mag(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
            logic [ACC_W-1:0] d;
            d = a - b;
            return d[ACC_W-1] ? (MAG_W'(1) << ACC_W) - {1'b0, d} : {1'b0, d};
        endfunction

        function logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] cand;
            res = '0;
            for (int b = 26; b >= 0; b--) begin
                cand = res | (64'd1 << b);
                if (cand * cand <= v)
                    res = cand;
            end
            return res;
        endfunction

        function void note_sample(sample_t smp);
            logic [MAG_W-1:0]   mx, my, mz;
            logic [63:0]        sum_sq;
            logic [63:0]        jerk_wide;
            logic [STAMP_W-1:0] dt;
            logic [STAMP_W-1:0] age;
            logic [RUN_W:0]     run_next;
            result_t            r;
            mx     = wrap_mag(smp.accel_x, prior.accel_x);
            my     = wrap_mag(smp.accel_y, prior.accel_y);
            mz     = wrap_mag(smp.accel_z, prior.accel_z);
            sum_sq = 64'(mx) * 64'(mx) + 64'(my) * 64'(my) + 64'(mz) * 64'(mz);
            dt     = smp.stamp_ms - prior.stamp_ms;
            r      = '0;
            if (dt == '0 || dt[STAMP_W-1]) begin
                jerk_wide = 64'(JERK_MAX);
            end else begin
                jerk_wide = root_floor(sum_sq << (2 * FRAC)) / 64'(dt);
                if (jerk_wide > 64'(JERK_MAX))
                    jerk_wide = 64'(JERK_MAX);
            end
            r.jerk_value = jerk_wide[JERK_W-1:0];
            if (r.jerk_value > motion_limit)
                motion_stamp = smp.stamp_ms;
            if (r.jerk_value > fault_limit) begin
                run_next = {1'b0, fault_run} + 1'b1;
                if (run_next > {1'b0, run_limit}) begin
                    r.reinit_request = 1'b1;
                    fault_run        = '0;
                end else begin
                    fault_run = run_next[RUN_W-1:0];
                end
            end else begin
                fault_run = '0;
            end
            age           = smp.stamp_ms - motion_stamp;
            r.motion      = age[STAMP_W-1] || age <= STAMP_W'(hold_ms);
            r.upside_down = smp.accel_z[ACC_W-1];
            prior         = smp;
            pending_results.push_back(r);
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] word);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result word %h with nothing outstanding", word);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (word[JERK_W-1:0] !== want.jerk_value) begin
                $error("jerk_value: expected %0d, actual %0d", want.jerk_value,
                       word[JERK_W-1:0]);
                errors++;
            end
            if (word[JERK_W] !== want.motion) begin
                $error("motion: expected %0d, actual %0d", want.motion, word[JERK_W]);
                errors++;
            end
            if (word[JERK_W+1] !== want.reinit_request) begin
                $error("reinit_request: expected %0d, actual %0d", want.reinit_request,
                       word[JERK_W+1]);
                errors++;
            end
            if (word[JERK_W+2] !== want.upside_down) begin
                $error("upside_down: expected %0d, actual %0d", want.upside_down,
                       word[JERK_W+2]);
                errors++;
            end
            if (word[OUT_DATA_W-1:JERK_W+3] !== '0) begin
                $error("zero fill: expected 0, actual %0h", word[OUT_DATA_W-1:JERK_W+3]);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    jerk_tracker tracker = new();
    sample_t     last_sent = '0;
    track_mode_t track_mode = TRACK_QUIET;
    bit          no_idle = 1'b0;
    int          cycle_count = 0;

    jerk_motion_detector_top #(.FRAC_BITS(FRAC)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("jerk_motion_detector_top: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_word(m_tdata);
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_sample(sample_t smp);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {smp.stamp_ms, smp.accel_z, smp.accel_y, smp.accel_x};
        do @(posedge aclk); while (!s_tready);
        tracker.note_sample(smp);
        last_sent = smp;
    endtask

    task automatic send_xyz(int x, int y, int z, logic [STAMP_W-1:0] stamp);
        sample_t smp;
        smp.accel_x  = ACC_W'(x);
        smp.accel_y  = ACC_W'(y);
        smp.accel_z  = ACC_W'(z);
        smp.stamp_ms = stamp;
        send_sample(smp);
    endtask

    // stop feeding until every word is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic set_limits(logic [CFG_DATA_W-1:0] motion_lim, logic [CFG_DATA_W-1:0] fault_lim,
                              logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] run_lim);
        write_reg(REG_MOTION_LIMIT, motion_lim);
        write_reg(REG_FAULT_LIMIT, fault_lim);
        if ($urandom_range(1))
            write_reg(CFG_IDX_W'($urandom_range(REG_FAULT_RUN + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        write_reg(REG_HOLD_WINDOW, hold);
        write_reg(REG_FAULT_RUN, run_lim);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ACC_W-1:0] nudge(logic [ACC_W-1:0] v, int span);
        return v + ACC_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // sample tracks: mostly rising stamps with a burst-wise jerk level,
    // the rest bad time steps, long silences and pure noise
    task automatic next_sample(output sample_t smp);
        int pick;
        int span;
        if ($urandom_range(9) == 0)
            track_mode = track_mode_t'($urandom_range(TRACK_VIOLENT));
        case (track_mode)
            TRACK_QUIET:  span = 4;
            TRACK_MOVING: span = 400;
            default:      span = 40000;
        endcase
        pick = $urandom_range(99);
        smp  = last_sent;
        if (pick < 8) begin
            smp.accel_x  = ACC_W'($urandom);
            smp.accel_y  = ACC_W'($urandom);
            smp.accel_z  = ACC_W'($urandom);
            smp.stamp_ms = $urandom;
        end else begin
            smp.accel_x = nudge(last_sent.accel_x, span);
            smp.accel_y = nudge(last_sent.accel_y, span);
            smp.accel_z = nudge(last_sent.accel_z, span);
            if (pick < 14)
                smp.stamp_ms = last_sent.stamp_ms - $urandom_range(50);
            else if (pick < 19)
                smp.stamp_ms = last_sent.stamp_ms + $urandom_range(150, 5000);
            else
                smp.stamp_ms = last_sent.stamp_ms + $urandom_range(1, 40);
        end
    endtask

    task automatic run_random(int count);
        sample_t smp;
        repeat (count) begin
            next_sample(smp);
            send_sample(smp);
        end
    endtask

    task automatic run_directed();
        send_xyz(0, 0, 0, 32'd0);                       // first word, zero step
        send_xyz(32767, -32768, 1, 32'd1);
        send_xyz(-32768, 32767, -1, 32'd2);             // differences wrap to small
        send_xyz(-32768, 32767, -1, 32'd2);
        send_xyz(0, 0, 0, 32'd1);                       // stamp goes back
        send_xyz(0, 0, 0, 32'd3);
        repeat (5) send_xyz(0, 0, 0, 32'd3);            // implausible run, reinit
        send_xyz(0, 0, 0, 32'd203);                     // hold window edge
        send_xyz(0, 0, 0, 32'd204);
        send_xyz(0, 0, 0, 32'h8000_00CB);               // largest positive step
        send_xyz(100, -100, 50, 32'hFFFF_FFF0);
        send_xyz(-100, 100, -50, 32'h0000_0010);        // stamp wrap
        send_xyz(-100, 100, -50, 32'h0000_00D9);
        send_xyz(32767, 32767, 32767, 32'h0000_00DA);   // near full-scale jerk
        send_xyz(-32768, -32768, -32768, 32'h0000_00DB);
        send_xyz(32767, -32768, 0, 32'h0000_05C3);
        send_xyz(-1, -1, -32768, 32'hFFFF_FFFF);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(150);
        drain();

        set_limits('0, '0, '0, '0);
        run_random(120);
        drain();

        set_limits('1, '1, '1, '1);
        run_random(120);
        drain();

        repeat (4) begin
            set_limits(CFG_DATA_W'($urandom_range(3000)),
                       $urandom_range(1) ? CFG_DATA_W'($urandom_range(1000, 300000))
                                         : CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom_range(400)) | (CFG_DATA_W'($urandom) & 24'hFF0000),
                       CFG_DATA_W'($urandom));
            run_random(150);
            drain();
        end

        no_idle = 1'b1;
        run_random(150);
        drain();
        no_idle = 1'b0;

        set_limits(CFG_DATA_W'(384), CFG_DATA_W'(128000), CFG_DATA_W'(200), CFG_DATA_W'(3));
        run_random(100);
        drain();

        if (tracker.errors == 0)
            $display("jerk_motion_detector_top: match");
        else
            $display("jerk_motion_detector_top: mismatch");
        $finish;
    end

endmodule
